// ===== hdl/dbq_pkg.sv =====
// Shared constants, operation codes and control structs for the bounded deque.
package dbq_pkg;

	localparam int unsigned DEPTH     = 16;
	localparam int unsigned WORD_W    = 32;
	localparam int unsigned COUNT_W   = $clog2(DEPTH + 1);
	localparam int unsigned MODE_W    = 3;
	localparam int unsigned IN_BYTES  = (MODE_W + WORD_W + 7) / 8;
	localparam int unsigned OUT_RAW_W = 1 + 3 * WORD_W + 2 + COUNT_W;
	localparam int unsigned OUT_BYTES = (OUT_RAW_W + 7) / 8;

	localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 3'd0;
	localparam logic [MODE_W-1:0] MODE_PUSH_REAR  = 3'd1;
	localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 3'd2;
	localparam logic [MODE_W-1:0] MODE_POP_REAR   = 3'd3;
	localparam logic [MODE_W-1:0] MODE_QUERY      = 3'd4;

	localparam logic [WORD_W-1:0]  NEG_ONE     = '1;
	localparam logic [COUNT_W-1:0] CAP_RESET   = COUNT_W'(DEPTH);

	typedef logic [WORD_W-1:0] word_t;

	// Decoded operation for one beat.
	typedef struct packed {
		logic ok;
		logic push_front;
		logic push_rear;
		logic pop_front;
		logic pop_rear;
	} dbq_dec_t;

	// Per-cell control: shift toward rear, shift toward front, load pushed word.
	typedef struct packed {
		logic shr;
		logic shl;
		logic ld;
	} dbq_cell_ctl_t;

endpackage

// ===== hdl/bounded_double_ended_queue_top.sv =====
// Top level of the bounded deque: cell row, decoder and output register.
//
// Usage:
// The s_axis channel carries one operation per beat (push front, push rear,
// pop front, pop rear, query). The m_axis channel returns exactly one result
// beat per operation, in order. The cfg channel writes the capacity register
// and is always ready; write it only while no operation is in flight.
// Words live in a row of 16 cells, with the front word always in cell 0.
// Push front and pop front shift the whole row by one cell in the same cycle;
// push rear loads the cell just past the rear; pop rear only drops the count.
// The cells and the count update when the operation beat is taken; the read
// stage then reads front and rear words into the output register, which holds
// the result beat. Throughput: one operation per cycle while m_tready keeps
// up; the one-hot rear select over 16 cells bounds the path.
// When m_tready is low, the result waits in the output register, one more
// operation may sit in the read stage, and s_tready then drops until the
// output register drains.
// Reset clears the count, the stages and the capacity (back to 16); the cell
// words are not reset and are only read at positions below the count.
module bounded_double_ended_queue_top (
	input  logic         clk,
	input  logic         arst_n,
	// cfg channel: capacity[4:0]
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [4:0]   cfg_data,
	// s_tdata: mode[2:0], push_value[34:3], zero fill above
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [39:0]  s_tdata,
	// m_tdata: accepted[0], popped_value[32:1], front_value[64:33],
	// rear_value[96:65], is_empty[97], is_full[98], occupancy[103:99]
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [103:0] m_tdata
);
	import dbq_pkg::*;

	logic [COUNT_W-1:0] capacity_q;
	logic [COUNT_W-1:0] count_q;
	logic [COUNT_W-1:0] count_next;
	dbq_dec_t           dec;
	logic               take;

	logic [MODE_W-1:0]  in_mode;
	word_t              in_push;

	word_t              cell_data [DEPTH];
	dbq_cell_ctl_t      cell_ctl  [DEPTH];
	word_t              rear_word;

	// Read stage: state already updated, popped word and flag captured.
	logic               s1_valid_q;
	logic               ok_s1;
	word_t              popped_s1;

	logic               out_load;
	logic               m_tvalid_q;
	logic [OUT_RAW_W-1:0] m_data_q;
	logic [COUNT_W-1:0] cap_eff;

	assign in_mode = s_tdata[MODE_W-1:0];
	assign in_push = s_tdata[MODE_W +: WORD_W];

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAP_RESET;
		end else if (cfg_valid) begin
			capacity_q <= cfg_data;
		end
	end

	dbq_ctrl u_ctrl (
		.mode       (in_mode),
		.count      (count_q),
		.capacity   (capacity_q),
		.dec        (dec),
		.count_next (count_next)
	);

	// The cell row. Cell 0 takes the pushed word on a front shift; the last
	// cell refills from itself on a front pop, past the count where nobody reads.
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		assign cell_ctl[i].shr = take && dec.push_front;
		assign cell_ctl[i].shl = take && dec.pop_front;
		assign cell_ctl[i].ld  = take && dec.push_rear && (count_q == COUNT_W'(i));

		dbq_cell u_cell (
			.clk        (clk),
			.ctl        (cell_ctl[i]),
			.left_data  ((i == 0) ? in_push : cell_data[(i == 0) ? 0 : i - 1]),
			.right_data (cell_data[(i == DEPTH - 1) ? i : i + 1]),
			.push_value (in_push),
			.data       (cell_data[i])
		);
	end

	// Rear word: the cell just below the count, picked by a one-hot select.
	always_comb begin
		rear_word = '0;
		for (int k = 0; k < DEPTH; k++) begin
			if (count_q == COUNT_W'(k + 1)) begin
				rear_word = rear_word | cell_data[k];
			end
		end
	end

	assign out_load = s1_valid_q && (!m_tvalid_q || m_tready);
	assign s_tready = !s1_valid_q || !m_tvalid_q || m_tready;
	assign take     = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			s1_valid_q <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (take) begin
				count_q    <= count_next;
				s1_valid_q <= 1'b1;
			end else if (out_load) begin
				s1_valid_q <= 1'b0;
			end
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			ok_s1 <= dec.ok;
			if (dec.pop_front) begin
				popped_s1 <= cell_data[0];
			end else if (dec.pop_rear) begin
				popped_s1 <= rear_word;
			end else begin
				popped_s1 <= NEG_ONE;
			end
		end
	end

	assign cap_eff = (capacity_q > COUNT_W'(DEPTH)) ? COUNT_W'(DEPTH) : capacity_q;

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_data_q <= {count_q,
				(count_q == cap_eff),
				(count_q == '0),
				(count_q == '0) ? NEG_ONE : rear_word,
				(count_q == '0) ? NEG_ONE : cell_data[0],
				popped_s1,
				ok_s1};
		end
	end

	assign m_tvalid = m_tvalid_q;
	// The packed result already fills whole bytes, so no zero fill is needed.
	assign m_tdata  = m_data_q;

endmodule

// ===== hdl/dbq_ctrl.sv =====
// Operation decoder: refusal checks and next word count.
module dbq_ctrl (
	input  logic [2:0]          mode,
	input  logic [4:0]          count,
	input  logic [4:0]          capacity,
	output dbq_pkg::dbq_dec_t   dec,
	output logic [4:0]          count_next
);
	import dbq_pkg::*;

	logic [COUNT_W-1:0] cap_eff;
	logic               room;
	logic               any;

	assign cap_eff = (capacity > COUNT_W'(DEPTH)) ? COUNT_W'(DEPTH) : capacity;
	assign room    = count < cap_eff;
	assign any     = count != '0;

	always_comb begin
		dec = '0;
		dec.ok = 1'b1;
		unique case (mode)
			MODE_PUSH_FRONT: begin
				dec.ok         = room;
				dec.push_front = room;
			end
			MODE_PUSH_REAR: begin
				dec.ok        = room;
				dec.push_rear = room;
			end
			MODE_POP_FRONT: begin
				dec.ok        = any;
				dec.pop_front = any;
			end
			MODE_POP_REAR: begin
				dec.ok       = any;
				dec.pop_rear = any;
			end
			default: begin
				dec.ok = 1'b1;
			end
		endcase
	end

	always_comb begin
		count_next = count;
		if (dec.push_front || dec.push_rear) begin
			count_next = count + COUNT_W'(1);
		end else if (dec.pop_front || dec.pop_rear) begin
			count_next = count - COUNT_W'(1);
		end
	end

endmodule

// ===== hdl/dbq_cell.sv =====
// One deque cell: holds a word and trades it with its neighbors.
module dbq_cell (
	input  logic                    clk,
	input  dbq_pkg::dbq_cell_ctl_t  ctl,
	input  logic [31:0]             left_data,
	input  logic [31:0]             right_data,
	input  logic [31:0]             push_value,
	output logic [31:0]             data
);
	import dbq_pkg::*;

	word_t data_q;

	always_ff @(posedge clk) begin
		if (ctl.shr) begin
			data_q <= left_data;
		end else if (ctl.shl) begin
			data_q <= right_data;
		end else if (ctl.ld) begin
			data_q <= push_value;
		end
	end

	assign data = data_q;

endmodule

// ===== hdl/dbq_checker.sv =====
// Port-level checker for the bounded deque, bound to the top level.
module dbq_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [103:0] m_tdata
);
	import dbq_pkg::*;

	// A stalled result holds its contents.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result beat changed while stalled");

	// The empty flag agrees with the reported count.
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[97] == (m_tdata[103:99] == '0)))
		else $error("empty flag disagrees with occupancy");

	// The count never exceeds the cell row.
	a_bound: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[103:99] <= COUNT_W'(DEPTH))
		else $error("occupancy beyond depth");

	// An empty queue reports both end words as minus one.
	a_ends: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[97] |-> m_tdata[64:33] == NEG_ONE && m_tdata[96:65] == NEG_ONE)
		else $error("end words of empty queue not minus one");

	// A refused operation never returns a popped word.
	a_refused: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[0] |-> m_tdata[32:1] == NEG_ONE)
		else $error("refused operation returned a word");

endmodule

bind bounded_double_ended_queue_top dbq_checker u_dbq_checker (.*);

// ===== sim/testbench.sv =====
// Self-checking testbench for the bounded deque: directed table, random phases, stalls.
module testbench;
	import dbq_pkg::*;

	// Operation codes above the query code; the block treats them as queries.
	localparam logic [MODE_W-1:0] MODE_SPARE_5 = 3'd5;
	localparam logic [MODE_W-1:0] MODE_SPARE_6 = 3'd6;
	localparam logic [MODE_W-1:0] MODE_SPARE_7 = 3'd7;

	localparam int unsigned ITEMS_PER_PHASE = 150;
	localparam int unsigned PHASES          = 9;
	localparam int unsigned HOLD_CYCLES     = 80;
	localparam int unsigned CYCLE_LIMIT     = 200000;

	// Capacity used by each random phase; phase 7 draws its own at random.
	localparam logic [4:0] PHASE_CAP [PHASES] = '{5'd16, 5'd0, 5'd31, 5'd1, 5'd17,
		5'd4, 5'd16, 5'd9, 5'd16};

	// One result beat, laid out so that a plain cast of m_tdata fills it:
	// the first member sits in the highest bits, accepted in bit 0.
	typedef struct packed {
		logic [COUNT_W-1:0] occupancy;
		logic               full;
		logic               empty;
		word_t              rear;
		word_t              front;
		word_t              popped;
		logic               accepted;
	} deque_status_t;

	typedef enum logic {ROW_OP, ROW_CFG} row_kind_t;

	// One row of the directed table. For a capacity row the value holds the
	// new capacity. Where known is set, want is the expected status as typed.
	typedef struct packed {
		row_kind_t         kind;
		logic [MODE_W-1:0] mode;
		word_t             value;
		logic              known;
		deque_status_t     want;
	} plan_row_t;

	logic           clk;
	logic           arst_n;
	logic           cfg_valid;
	logic           cfg_ready;
	logic [4:0]     cfg_data;
	logic           s_tvalid;
	logic           s_tready;
	logic [39:0]    s_tdata;
	logic           m_tvalid;
	logic           m_tready;
	logic [103:0]   m_tdata;

	// Shadow copy of the deque: a circular store addressed from the front slot.
	word_t          shadow_words [DEPTH];
	logic [3:0]     front_slot;
	logic [4:0]     word_total;
	logic [4:0]     capacity_reg;

	// Statuses predicted for operations taken but not yet answered, oldest first.
	deque_status_t  pending_status [$];
	plan_row_t      plan [$];

	int unsigned    send_idle_pct;
	int unsigned    recv_idle_pct;
	bit             hold_req;
	int unsigned    cycle_count;
	int unsigned    errors;
	int unsigned    ops_sent;
	int unsigned    results_checked;
	int unsigned    pushes_refused;
	int unsigned    pops_refused;
	int unsigned    caps_written;
	int unsigned    input_stalls;

	bounded_double_ended_queue_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Applies one operation to the shadow deque and returns the status the
	// block should report for it.
	function automatic deque_status_t apply_deque_op(input logic [MODE_W-1:0] mode,
		input word_t value);
		deque_status_t r;
		logic [4:0]    limit;
		limit = (capacity_reg > DEPTH) ? 5'(DEPTH) : capacity_reg;
		r = '0;
		r.accepted = 1'b1;
		r.popped = NEG_ONE;
		case (mode)
			MODE_PUSH_FRONT, MODE_PUSH_REAR: begin
				if (word_total >= limit) begin
					r.accepted = 1'b0;
				end else if (mode == MODE_PUSH_FRONT) begin
					front_slot = front_slot - 4'd1;
					shadow_words[front_slot] = value;
					word_total = word_total + 5'd1;
				end else begin
					// The new rear sits just past the old rear.
					shadow_words[4'(front_slot + word_total)] = value;
					word_total = word_total + 5'd1;
				end
			end
			MODE_POP_FRONT, MODE_POP_REAR: begin
				if (word_total == 0) begin
					r.accepted = 1'b0;
				end else if (mode == MODE_POP_FRONT) begin
					r.popped = shadow_words[front_slot];
					front_slot = front_slot + 4'd1;
					word_total = word_total - 5'd1;
				end else begin
					r.popped = shadow_words[4'(front_slot + word_total - 5'd1)];
					word_total = word_total - 5'd1;
				end
			end
			default: begin
				// Query and the spare codes leave the deque untouched.
			end
		endcase
		r.front = (word_total != 0) ? shadow_words[front_slot] : NEG_ONE;
		r.rear = (word_total != 0) ? shadow_words[4'(front_slot + word_total - 5'd1)] : NEG_ONE;
		r.empty = (word_total == 0);
		r.full = (word_total == limit);
		r.occupancy = word_total;
		return r;
	endfunction

	// Offers one operation beat, with random gaps before it, and records the
	// expected status once the beat is taken.
	task automatic send_op(input logic [MODE_W-1:0] mode, input word_t value,
		input logic use_given, input deque_status_t given);
		deque_status_t predicted;
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {5'b0, value, mode};
		do @(posedge clk); while (!s_tready);
		predicted = apply_deque_op(mode, value);
		if (!predicted.accepted && (mode == MODE_PUSH_FRONT || mode == MODE_PUSH_REAR))
			pushes_refused++;
		if (!predicted.accepted && (mode == MODE_POP_FRONT || mode == MODE_POP_REAR))
			pops_refused++;
		pending_status.push_back(use_given ? given : predicted);
		ops_sent++;
	endtask

	// Writes the capacity once every outstanding result has come back, so the
	// block is idle at the write.
	task automatic write_capacity(input logic [4:0] cap);
		s_tvalid <= 1'b0;
		while (pending_status.size() != 0) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= cap;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		capacity_reg = cap;
		caps_written++;
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			errors++;
		end
	endtask

	// Result side: the ready pattern follows the current idle rate, except for
	// one long hold-off requested by the stimulus, counted here in cycles.
	initial begin : result_sink
		int unsigned k;
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				for (k = 0; k < HOLD_CYCLES; k++) begin
					m_tready <= 1'b0;
					@(posedge clk);
				end
			end
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Every result beat is compared with the oldest expected status.
	always @(posedge clk) begin : result_check
		deque_status_t got;
		deque_status_t want;
		if (arst_n && s_tvalid && !s_tready)
			input_stalls++;
		if (arst_n && m_tvalid && m_tready) begin
			got = deque_status_t'(m_tdata);
			if (pending_status.size() == 0) begin
				$error("result beat arrived with no operation outstanding");
				errors++;
			end else begin
				want = pending_status.pop_front();
				check_field("accepted", 32'(want.accepted), 32'(got.accepted));
				check_field("popped_value", want.popped, got.popped);
				check_field("front_value", want.front, got.front);
				check_field("rear_value", want.rear, got.rear);
				check_field("is_empty", 32'(want.empty), 32'(got.empty));
				check_field("is_full", 32'(want.full), 32'(got.full));
				check_field("occupancy", 32'(want.occupancy), 32'(got.occupancy));
				results_checked++;
			end
		end
	end

	// Watchdog: a hung handshake ends the run as a failure.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin : stimulus
		logic [MODE_W-1:0] mode;
		word_t             value;
		logic [4:0]        cap;
		bit                filling;
		int unsigned       run_left;
		int unsigned       roll;

		arst_n <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_data <= '0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		hold_req = 1'b0;
		cycle_count = 0;
		errors = 0;
		ops_sent = 0;
		results_checked = 0;
		pushes_refused = 0;
		pops_refused = 0;
		caps_written = 0;
		input_stalls = 0;
		send_idle_pct = 32;
		recv_idle_pct = 51;
		filling = 1'b1;
		run_left = 0;

		foreach (shadow_words[i]) shadow_words[i] = '0;
		front_slot = '0;
		word_total = '0;
		capacity_reg = CAP_RESET;

		// Directed table. Known statuses read, from the left: occupancy, full,
		// empty, rear, front, popped, accepted.
		plan.push_back('{ROW_OP, MODE_QUERY, 32'h0, 1'b1,
			'{5'd0, 1'b0, 1'b1, NEG_ONE, NEG_ONE, NEG_ONE, 1'b1}});
		// Pops from the empty deque are refused and report -1.
		plan.push_back('{ROW_OP, MODE_POP_FRONT, 32'h0, 1'b1,
			'{5'd0, 1'b0, 1'b1, NEG_ONE, NEG_ONE, NEG_ONE, 1'b0}});
		plan.push_back('{ROW_OP, MODE_POP_REAR, 32'h0, 1'b1,
			'{5'd0, 1'b0, 1'b1, NEG_ONE, NEG_ONE, NEG_ONE, 1'b0}});
		plan.push_back('{ROW_OP, MODE_PUSH_FRONT, 32'h7FFF_FFFF, 1'b1,
			'{5'd1, 1'b0, 1'b0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, NEG_ONE, 1'b1}});
		plan.push_back('{ROW_OP, MODE_PUSH_REAR, 32'h8000_0000, 1'b0, '0});
		plan.push_back('{ROW_OP, MODE_PUSH_FRONT, 32'h0, 1'b0, '0});
		plan.push_back('{ROW_OP, MODE_PUSH_REAR, NEG_ONE, 1'b0, '0});
		// Spare codes behave as queries and ignore their data.
		plan.push_back('{ROW_OP, MODE_SPARE_5, 32'hAAAA_AAAA, 1'b0, '0});
		plan.push_back('{ROW_OP, MODE_SPARE_6, 32'h5555_5555, 1'b0, '0});
		plan.push_back('{ROW_OP, MODE_SPARE_7, NEG_ONE, 1'b0, '0});
		plan.push_back('{ROW_OP, MODE_POP_FRONT, 32'h0, 1'b0, '0});
		plan.push_back('{ROW_OP, MODE_POP_REAR, 32'h0, 1'b0, '0});
		// Capacity dropped below the two words held: pushes refused, pops work.
		plan.push_back('{ROW_CFG, MODE_QUERY, 32'd1, 1'b0, '0});
		plan.push_back('{ROW_OP, MODE_PUSH_REAR, 32'h5, 1'b0, '0});
		plan.push_back('{ROW_OP, MODE_POP_FRONT, 32'h0, 1'b0, '0});
		plan.push_back('{ROW_OP, MODE_POP_REAR, 32'h0, 1'b0, '0});
		// Zero capacity: the empty deque also reads as full.
		plan.push_back('{ROW_CFG, MODE_QUERY, 32'd0, 1'b0, '0});
		plan.push_back('{ROW_OP, MODE_QUERY, 32'h0, 1'b1,
			'{5'd0, 1'b1, 1'b1, NEG_ONE, NEG_ONE, NEG_ONE, 1'b1}});
		plan.push_back('{ROW_OP, MODE_PUSH_FRONT, 32'd123, 1'b1,
			'{5'd0, 1'b1, 1'b1, NEG_ONE, NEG_ONE, NEG_ONE, 1'b0}});
		// A capacity above the store depth acts as the depth.
		plan.push_back('{ROW_CFG, MODE_QUERY, 32'd31, 1'b0, '0});
		plan.push_back('{ROW_OP, MODE_PUSH_REAR, 32'h1234_5678, 1'b0, '0});
		plan.push_back('{ROW_OP, MODE_POP_FRONT, 32'h0, 1'b0, '0});

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			if (plan[i].kind == ROW_CFG)
				write_capacity(plan[i].value[4:0]);
			else
				send_op(plan[i].mode, plan[i].value, plan[i].known, plan[i].want);
		end

		// Random phases. Each starts from an idle block with a new capacity and
		// leaves the words held, so a smaller capacity can land below the count.
		for (int ph = 0; ph < PHASES; ph++) begin
			if (ph < 3) begin
				send_idle_pct = 32;
				recv_idle_pct = 51;
			end else if (ph < 6) begin
				send_idle_pct = 51;
				recv_idle_pct = 32;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			cap = (ph == 7) ? 5'($urandom_range(31)) : PHASE_CAP[ph];
			write_capacity(cap);
			// With no idling on either side, a long receiver hold-off backs up
			// the pipeline until the input stalls.
			if (ph == 6)
				hold_req = 1'b1;
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				// Alternate runs biased toward filling and toward draining, so the
				// deque swings between empty and full.
				if (run_left == 0) begin
					filling = ~filling;
					run_left = $urandom_range(24, 4);
				end
				run_left--;
				roll = $urandom_range(99);
				if (roll < 8)
					mode = 3'($urandom_range(7, 4));
				else if (roll < (filling ? 70 : 30))
					mode = $urandom_range(1) ? MODE_PUSH_REAR : MODE_PUSH_FRONT;
				else
					mode = $urandom_range(1) ? MODE_POP_REAR : MODE_POP_FRONT;
				if ($urandom_range(9) == 0) begin
					case ($urandom_range(3))
						0: value = 32'h7FFF_FFFF;
						1: value = 32'h8000_0000;
						2: value = NEG_ONE;
						default: value = '0;
					endcase
				end else begin
					value = $urandom;
				end
				send_op(mode, value, 1'b0, '0);
			end
		end

		s_tvalid <= 1'b0;
		while (pending_status.size() != 0) @(posedge clk);
		// Any stray beat after the last expected one is caught by the checker.
		repeat (8) @(posedge clk);

		$display("Ran %0d operations over %0d capacity writes; %0d results checked.",
			ops_sent, caps_written, results_checked);
		$display("Refused %0d pushes and %0d pops; input stalled for %0d cycles.",
			pushes_refused, pops_refused, input_stalls);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
